// ===== design/lsa_pkg.sv =====
// ---------------------------------------------------------------------------
// lsa_pkg: shared types and constants
// Command and status structs between controller and datapath, item codes.
// ---------------------------------------------------------------------------
package lsa_pkg;

	localparam int CNT_W            = 11;
	localparam int VAL_W            = 32;
	localparam int SUM_W            = 64;
	localparam int DEF_MAX_ELEMENTS = 1024;
	localparam int RESET_COUNT      = 1024;

	localparam logic [1:0] KIND_LOAD  = 2'd0;
	localparam logic [1:0] KIND_BUILD = 2'd1;
	localparam logic [1:0] KIND_ADD   = 2'd2;
	localparam logic [1:0] KIND_SUM   = 2'd3;

	typedef struct packed {
		logic capture;   // take the item on the request channel
		logic clr_wr;    // clearing pass write, advance pointer
		logic step;      // issue read at pointer, advance pointer
		logic out_load;  // fill output register
	} cmd_t;

	typedef struct packed {
		logic at_end;    // pointer on last index of the sweep
		logic ok;        // captured item has a non-empty valid range
		logic is_sum;    // captured item is a range sum
		logic in_load;   // item on the request channel is a load
		logic out_busy;  // output register cannot take a result
	} sts_t;

endpackage

// ===== design/lsa_if.sv =====
// ---------------------------------------------------------------------------
// lsa_req_if / lsa_rsp_if: request and result channels
// Valid/ready channels carrying one item each.
// ---------------------------------------------------------------------------
interface lsa_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [10:0] left_index;
	logic [10:0] right_index;
	logic signed [31:0] value;

	modport source (output valid, kind, left_index, right_index, value, input ready);
	modport sink   (input valid, kind, left_index, right_index, value, output ready);
endinterface

interface lsa_rsp_if;
	logic        valid;
	logic        ready;
	logic signed [63:0] range_sum;
	logic        range_error;

	modport source (output valid, range_sum, range_error, input ready);
	modport sink   (input valid, range_sum, range_error, output ready);
endinterface

// ===== design/lazy_segment_tree_range_add_sum_unit.sv =====
// ---------------------------------------------------------------------------
// lazy_segment_tree_range_add_sum_unit: range add / range sum store
// Signed element store with load, build, range add and range sum commands.
// ---------------------------------------------------------------------------
// Channel   Dir  Carries
// req       in   kind, left_index, right_index, value
// rsp       out  range_sum, range_error (range sum items only)
// cfg       in   element_count, write only
//
// A load is taken at capture. Build, add and sum run the check, sweep and drain
// states, one element per cycle (length is the element count for build, else the
// range); a sum then runs the put state. A rejected add or empty build goes from
// check back to idle, a rejected sum to put. After reset a clearing pass over
// min(1024, MAX_ELEMENTS) elements runs first. A sum waits in put while the output
// register holds an unaccepted item; loads, builds and adds never wait on the output.
module lazy_segment_tree_range_add_sum_unit import lsa_pkg::*; #(
	parameter int MAX_ELEMENTS = DEF_MAX_ELEMENTS
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wr_en,
	input  logic [CNT_W-1:0] cfg_wr_data,
	lsa_req_if.sink          req,
	lsa_rsp_if.source        rsp
);
	cmd_t cmd;
	sts_t sts;

	lsa_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .req_valid(req.valid), .req_ready(req.ready),
		.sts(sts), .cmd(cmd)
	);

	lsa_dp #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.kind(req.kind), .left_index(req.left_index), .right_index(req.right_index),
		.value(req.value), .cmd(cmd), .sts(sts), .rsp(rsp)
	);
endmodule

// ===== design/lsa_ram.sv =====
// ---------------------------------------------------------------------------
// lsa_ram: simple dual-port RAM
// One write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module lsa_ram #(
	parameter int W = 64,
	parameter int D = 1024
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0]         rdata
);
	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== design/lsa_ctrl.sv =====
// ---------------------------------------------------------------------------
// lsa_ctrl: sequencing state machine
// Runs the reset clearing pass, item capture, sweeps and result hand-off.
// ---------------------------------------------------------------------------
module lsa_ctrl import lsa_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  sts_t sts,
	output cmd_t cmd
);
	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_CHECK = 3'd2;
	localparam logic [2:0] S_SWEEP = 3'd3;
	localparam logic [2:0] S_DRAIN = 3'd4;
	localparam logic [2:0] S_PUT   = 3'd5;

	logic [2:0] state_q, state_d;

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (sts.at_end) state_d = S_IDLE;
			end
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.capture = 1'b1;
					if (!sts.in_load) state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				if (sts.ok)          state_d = S_SWEEP;
				else if (sts.is_sum) state_d = S_PUT;
				else                 state_d = S_IDLE;
			end
			S_SWEEP: begin
				cmd.step = 1'b1;
				if (sts.at_end) state_d = S_DRAIN;
			end
			S_DRAIN: begin
				state_d = sts.is_sum ? S_PUT : S_IDLE;
			end
			S_PUT: begin
				if (!sts.out_busy) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end
endmodule

// ===== design/lsa_dp.sv =====
// ---------------------------------------------------------------------------
// lsa_dp: element store datapath
// Element RAMs, sweep pointer, adder stage, accumulator and output register.
// ---------------------------------------------------------------------------
module lsa_dp import lsa_pkg::*; #(
	parameter int MAX_ELEMENTS = DEF_MAX_ELEMENTS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [CNT_W-1:0]  cfg_wr_data,
	input  logic [1:0]        kind,
	input  logic [CNT_W-1:0]  left_index,
	input  logic [CNT_W-1:0]  right_index,
	input  logic [VAL_W-1:0]  value,
	input  cmd_t              cmd,
	output sts_t              sts,
	lsa_rsp_if.source         rsp
);
	localparam int AW = $clog2(MAX_ELEMENTS);
	localparam int INIT_BUILT = (RESET_COUNT > MAX_ELEMENTS) ? MAX_ELEMENTS : RESET_COUNT;

	logic [CNT_W-1:0] count_q, built_q, ptr_q, end_q, clamp;
	logic [1:0]       op_q;
	logic [VAL_W-1:0] val_q;
	logic             ok_q, out_valid_q;
	logic [SUM_W-1:0] acc_q, el_rd, el_wdata, sum_q;
	logic [VAL_W-1:0] ld_rd;
	logic             err_q, v_s1, el_we, ld_we;
	logic [AW-1:0]    rd_addr, a_s1, el_waddr;

	assign clamp = (32'(count_q) > MAX_ELEMENTS) ? CNT_W'(MAX_ELEMENTS) : count_q;
	assign rd_addr = AW'(ptr_q - CNT_W'(1));

	assign ld_we = cmd.capture && kind == KIND_LOAD && left_index != '0
		&& 32'(left_index) <= MAX_ELEMENTS;

	assign el_we    = cmd.clr_wr || (v_s1 && (op_q == KIND_ADD || op_q == KIND_BUILD));
	assign el_waddr = cmd.clr_wr ? rd_addr : a_s1;
	always_comb begin
		if (cmd.clr_wr)              el_wdata = '0;
		else if (op_q == KIND_BUILD) el_wdata = {{(SUM_W-VAL_W){ld_rd[VAL_W-1]}}, ld_rd};
		else el_wdata = el_rd + {{(SUM_W-VAL_W){val_q[VAL_W-1]}}, val_q};
	end

	lsa_ram #(.W(SUM_W), .D(MAX_ELEMENTS)) u_elem (
		.clk(clk), .we(el_we), .waddr(el_waddr), .wdata(el_wdata),
		.raddr(rd_addr), .rdata(el_rd)
	);

	lsa_ram #(.W(VAL_W), .D(MAX_ELEMENTS)) u_load (
		.clk(clk), .we(ld_we), .waddr(AW'(left_index - CNT_W'(1))), .wdata(value),
		.raddr(rd_addr), .rdata(ld_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= CNT_W'(RESET_COUNT);
			built_q     <= CNT_W'(INIT_BUILT);
			ptr_q       <= CNT_W'(1);
			end_q       <= CNT_W'(INIT_BUILT);
			op_q        <= KIND_LOAD;
			ok_q        <= 1'b0;
			v_s1        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) count_q <= cfg_wr_data;
			v_s1 <= cmd.step;
			if (cmd.capture) begin
				op_q <= kind;
				if (kind == KIND_BUILD) begin
					built_q <= clamp;
					ptr_q   <= CNT_W'(1);
					end_q   <= clamp;
					ok_q    <= clamp != '0;
				end else begin
					ptr_q <= left_index;
					end_q <= right_index;
					ok_q  <= left_index != '0 && left_index <= right_index
						&& right_index <= built_q;
				end
			end else if (cmd.clr_wr || cmd.step) begin
				ptr_q <= ptr_q + CNT_W'(1);
			end
			if (cmd.out_load)             out_valid_q <= 1'b1;
			else if (rsp.ready)           out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		a_s1 <= rd_addr;
		if (cmd.capture) begin
			val_q <= value;
			acc_q <= '0;
		end else if (v_s1 && op_q == KIND_SUM) begin
			acc_q <= acc_q + el_rd;
		end
		if (cmd.out_load) begin
			sum_q <= acc_q;
			err_q <= !ok_q;
		end
	end

	assign sts.at_end   = ptr_q == end_q;
	assign sts.ok       = ok_q;
	assign sts.is_sum   = op_q == KIND_SUM;
	assign sts.in_load  = kind == KIND_LOAD;
	assign sts.out_busy = out_valid_q && !rsp.ready;

	assign rsp.valid       = out_valid_q;
	assign rsp.range_sum   = sum_q;
	assign rsp.range_error = err_q;
endmodule

// ===== design/lsa_chk.sv =====
// ---------------------------------------------------------------------------
// lsa_chk: port-level checks
// Result channel behaviour and item sequencing seen at the ports.
// ---------------------------------------------------------------------------
module lsa_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic [1:0]  req_kind,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [63:0] rsp_sum,
	input logic        rsp_error
);
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result dropped while stalled");

	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(rsp_sum) && $stable(rsp_error))
		else $error("result changed while stalled");

	a_busy_after_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req_kind != 2'd0 |=> !req_ready)
		else $error("ready held after a non-load item");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_error |-> rsp_sum == 64'd0)
		else $error("rejected range with non-zero sum");
endmodule

bind lazy_segment_tree_range_add_sum_unit lsa_chk u_chk (
	.clk(clk), .arst_n(arst_n),
	.req_valid(req.valid), .req_ready(req.ready), .req_kind(req.kind),
	.rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
	.rsp_sum(rsp.range_sum), .rsp_error(rsp.range_error)
);

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench: lazy segment tree range add / range sum unit
// Drives load, build, range add and range sum items under random idling on
// both channels, keeps its own flat copy of the element array and checks
// every range sum result field by field against it.
// ---------------------------------------------------------------------------
module testbench;
	import lsa_pkg::*;

	localparam int MAX_EL     = DEF_MAX_ELEMENTS;
	localparam int IDLE_LIMIT = 20000;
	localparam int SETTLE     = 1100;

	typedef struct {
		logic [63:0] sum;
		logic        err;
	} sum_result_t;

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic [CNT_W-1:0] cfg_wr_data;

	lsa_req_if req ();
	lsa_rsp_if rsp ();

	lazy_segment_tree_range_add_sum_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.req        (req),
		.rsp        (rsp)
	);

	// element model: tree sums are linear mod 2^64, so a flat array suffices
	logic [63:0] elem_sum[1:MAX_EL];
	logic [31:0] loaded[1:MAX_EL];
	bit          written[1:MAX_EL];
	int          built_count;
	int          count_reg;
	sum_result_t pending_sums[$];

	int  fail_count;
	int  mismatch_count;
	int  idle_cycles;
	bit  no_idle;
	bit  stall_req;
	int  stall_left;
	int  ready_gap;

	always #4 clk = ~clk;

	function automatic int clamp_count(int c);
		return (c > MAX_EL) ? MAX_EL : c;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 50);
	endfunction

	// apply an accepted item to the element model
	task automatic predict_item(logic [1:0] kind, int l, int r, logic [31:0] v);
		sum_result_t res;
		logic [63:0] amt;
		bit ok;
		amt = {{32{v[31]}}, v};
		ok = (l >= 1) && (l <= r) && (r <= built_count);
		case (kind)
			KIND_LOAD: begin
				if (l >= 1 && l <= MAX_EL) begin
					loaded[l] = v;
					written[l] = 1;
				end
			end
			KIND_BUILD: begin
				built_count = clamp_count(count_reg);
				for (int i = 1; i <= MAX_EL; i++)
					elem_sum[i] = (i <= built_count) ? {{32{loaded[i][31]}}, loaded[i]} : 64'd0;
			end
			KIND_ADD: begin
				if (ok)
					for (int i = l; i <= r; i++)
						elem_sum[i] += amt;
			end
			default: begin
				res.sum = 0;
				res.err = !ok;
				if (ok)
					for (int i = l; i <= r; i++)
						res.sum += elem_sum[i];
				pending_sums.push_back(res);
			end
		endcase
	endtask

	// entered and left at a rising edge
	task automatic send_item(logic [1:0] kind, int l, int r, logic [31:0] v);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid       <= 1'b1;
		req.kind        <= kind;
		req.left_index  <= l[10:0];
		req.right_index <= r[10:0];
		req.value       <= v;
		do
			@(posedge clk);
		while (!req.ready);
		predict_item(kind, l, r, v);
	endtask

	task automatic drain_and_settle();
		req.valid <= 1'b0;
		while (pending_sums.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_count(int c);
		drain_and_settle();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= c[10:0];
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		count_reg = c;
	endtask

	// never let a build read an element that was never loaded
	task automatic load_missing();
		for (int i = 1; i <= clamp_count(count_reg); i++)
			if (!written[i])
				send_item(KIND_LOAD, i, $urandom_range(0, 2047), $urandom);
	endtask

	task automatic build_tree();
		load_missing();
		send_item(KIND_BUILD, $urandom_range(0, 2047), $urandom_range(0, 2047), $urandom);
	endtask

	task automatic random_item(int lim);
		int k, l, r, c;
		c = (built_count > 0) ? built_count : 1;
		k = $urandom_range(0, 99);
		if ($urandom_range(0, 9) == 0) begin
			l = $urandom_range(0, 2047);
			r = $urandom_range(0, 2047);
			if (l + r > 600 && built_count > 100) begin
				l = l % 64;
				r = l + (r % 64);
			end
		end else begin
			l = $urandom_range(1, c);
			r = $urandom_range(l, (l + lim - 1 < c) ? l + lim - 1 : c);
		end
		if (k < 8)
			send_item(KIND_LOAD, $urandom_range(1, c), $urandom_range(0, 2047), $urandom);
		else if (k < 12)
			build_tree();
		else if (k < 52)
			send_item(KIND_ADD, l, r, $urandom);
		else
			send_item(KIND_SUM, l, r, $urandom);
	endtask

	task automatic test_directed();
		send_item(KIND_SUM, 1, 1024, 0);
		send_item(KIND_SUM, 0, 3, 0);
		write_count(8);
		send_item(KIND_LOAD, 1, 0, 32'h7fffffff);
		send_item(KIND_LOAD, 2, 2047, 32'h80000000);
		send_item(KIND_LOAD, 3, 5, 32'hffffffff);
		send_item(KIND_LOAD, 4, 5, 32'h0);
		send_item(KIND_LOAD, 0, 5, 32'h12345678);
		send_item(KIND_LOAD, 2047, 5, 32'h5a5a5a5a);
		build_tree();
		send_item(KIND_SUM, 1, 8, 0);
		send_item(KIND_ADD, 1, 8, 32'h7fffffff);
		send_item(KIND_ADD, 3, 5, 32'h80000000);
		send_item(KIND_ADD, 5, 4, 32'h1);
		send_item(KIND_ADD, 2, 9, 32'h1);
		send_item(KIND_SUM, 1, 1, 0);
		send_item(KIND_SUM, 2, 7, 0);
		send_item(KIND_SUM, 8, 8, 0);
		send_item(KIND_SUM, 4, 3, 0);
		send_item(KIND_SUM, 1, 9, 0);
		send_item(KIND_SUM, 0, 0, 0);
		write_count(0);
		build_tree();
		send_item(KIND_ADD, 1, 1, 5);
		send_item(KIND_SUM, 1, 1, 0);
		write_count(2047);
		build_tree();
		send_item(KIND_SUM, 1, 1024, 0);
		send_item(KIND_SUM, 1, 1025, 0);
	endtask

	task automatic test_random();
		int counts[14] = '{1, 2, 3, 1024, 17, 0, 40, 2047, 5, 64, 9, 33, 1, 100};
		int lim;
		for (int p = 0; p < 14; p++) begin
			write_count(counts[p] == 17 ? $urandom_range(4, 31) : counts[p]);
			build_tree();
			no_idle = (p % 4 == 3);
			lim = (built_count > 100) ? 200 : 2048;
			repeat ((built_count > 100) ? 10 : 15)
				random_item(lim);
		end
		no_idle = 0;
	endtask

	task automatic test_backpressure();
		write_count(12);
		build_tree();
		stall_req = 1;
		repeat (30) random_item(12);
		drain_and_settle();
		repeat (80) random_item(12);
	endtask

	// receiver: random ready with occasional long hold-offs
	always @(posedge clk) begin
		if (stall_req) begin
			stall_left = 400;
			stall_req = 0;
		end
		if (stall_left > 0) begin
			stall_left--;
			rsp.ready <= 1'b0;
		end else if (ready_gap > 0) begin
			ready_gap--;
			rsp.ready <= 1'b0;
		end else if (no_idle) begin
			rsp.ready <= 1'b1;
		end else begin
			int r;
			r = $urandom_range(0, 99);
			if (r < 94)
				rsp.ready <= (r < 75);
			else begin
				ready_gap = $urandom_range(10, 60);
				rsp.ready <= 1'b0;
			end
		end
	end

	// result check
	always @(posedge clk) begin
		if (arst_n && rsp.valid && rsp.ready) begin
			if (pending_sums.size() == 0) begin
				fail_count++;
				$display("unexpected result: sum %h err %b", rsp.range_sum, rsp.range_error);
			end else begin
				sum_result_t e;
				e = pending_sums.pop_front();
				if (rsp.range_sum !== e.sum || rsp.range_error !== e.err) begin
					fail_count++;
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("mismatch: sum exp %h got %h, err exp %b got %b",
							e.sum, rsp.range_sum, e.err, rsp.range_error);
				end
			end
		end
	end

	// watchdog on cycles without any handshake
	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
			idle_cycles = 0;
		else if (++idle_cycles >= IDLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		clk = 0;
		arst_n = 0;
		cfg_wr_en = 0;
		cfg_wr_data = 0;
		req.valid = 0;
		req.kind = KIND_LOAD;
		req.left_index = 0;
		req.right_index = 0;
		req.value = 0;
		rsp.ready = 0;
		fail_count = 0;
		mismatch_count = 0;
		idle_cycles = 0;
		no_idle = 0;
		stall_req = 0;
		stall_left = 0;
		ready_gap = 0;
		count_reg = RESET_COUNT;
		built_count = clamp_count(RESET_COUNT);
		for (int i = 1; i <= MAX_EL; i++) begin
			elem_sum[i] = 0;
			loaded[i] = 0;
			written[i] = 0;
		end
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random();
		test_backpressure();
		drain_and_settle();
		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
